>>> hw/rtl/xlb_pkg.sv
package xlb_pkg;

  localparam int MODE_W     = 2;
  localparam int VALUE_W    = 31;
  localparam int RANK_W     = 5;
  localparam int IN_DATA_W  = ((VALUE_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((1 + RANK_W + VALUE_W + 7) / 8) * 8;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 2'd0,
    MODE_TEST   = 2'd1,
    MODE_CLEAR  = 2'd2
  } mode_e;

  typedef struct packed {
    logic  vld;
    mode_e mode;
    logic  done;
  } ctl_t;

endpackage

>>> hw/rtl/xor_linear_basis.sv
// XOR linear basis over GF(2): one cell per basis row, ordered from the top
// bit down, each holding its row and a stage register. A request walks the
// chain one cell per cycle unless stalled, is reduced against each row,
// lands in the empty row of its leading bit on insert, and picks up the rank
// and the greedy maximum XOR on the way, so every response reflects the
// basis after its own step. The response is registered in each cell's stage
// register in turn; a new request enters every cycle unless stalled, while
// earlier requests are still in the chain.
// A stall on the response side holds the whole chain. Reset empties the basis
// at once; no clearing pass is needed.
module xor_linear_basis #(
  parameter int VECTOR_BITS = 31
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [xlb_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // value, zero pad
  input  logic [xlb_pkg::MODE_W-1:0]       s_axis_tuser,  // mode
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [xlb_pkg::OUT_DATA_W-1:0]   m_axis_tdata   // in_span, rank, max_xor, zero pad
);
  import xlb_pkg::*;

  localparam int W  = VECTOR_BITS;
  localparam int RW = $clog2(VECTOR_BITS + 1);

  ctl_t          ctl_s  [W+1];
  logic [W-1:0]  vec_s  [W+1];
  logic [W-1:0]  acc_s  [W+1];
  logic [RW-1:0] rank_s [W+1];
  logic          en;

  logic                in_span;
  logic [RANK_W-1:0]   rank;
  logic [VALUE_W-1:0]  max_xor;

  assign en            = !ctl_s[W].vld || m_axis_tready;
  assign s_axis_tready = en;

  assign ctl_s[0].vld  = s_axis_tvalid;
  assign ctl_s[0].mode = mode_e'(s_axis_tuser);
  assign ctl_s[0].done = 1'b0;
  assign acc_s[0]      = '0;
  assign rank_s[0]     = '0;

  generate
    if (W > VALUE_W) begin : g_vin_ext
      assign vec_s[0] = {{(W - VALUE_W){1'b0}}, s_axis_tdata[VALUE_W-1:0]};
    end else begin : g_vin_trunc
      assign vec_s[0] = s_axis_tdata[W-1:0];
    end
  endgenerate

  generate
    for (genvar k = 0; k < W; k++) begin : g_cell
      xlb_cell #(
        .W  (W),
        .RW (RW),
        .I  (W - 1 - k)
      ) u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .en_i   (en),
        .ctl_i  (ctl_s[k]),
        .vec_i  (vec_s[k]),
        .acc_i  (acc_s[k]),
        .rank_i (rank_s[k]),
        .ctl_o  (ctl_s[k+1]),
        .vec_o  (vec_s[k+1]),
        .acc_o  (acc_s[k+1]),
        .rank_o (rank_s[k+1])
      );
    end
  endgenerate

  assign in_span = ((ctl_s[W].mode == MODE_INSERT) || (ctl_s[W].mode == MODE_TEST))
                   && (vec_s[W] == '0);

  generate
    if (RW > RANK_W) begin : g_rank_sat
      assign rank = (rank_s[W] > RW'((1 << RANK_W) - 1)) ? {RANK_W{1'b1}}
                                                          : rank_s[W][RANK_W-1:0];
    end else if (RW == RANK_W) begin : g_rank_eq
      assign rank = rank_s[W];
    end else begin : g_rank_ext
      assign rank = {{(RANK_W - RW){1'b0}}, rank_s[W]};
    end
  endgenerate

  generate
    if (W >= VALUE_W) begin : g_max_trunc
      assign max_xor = acc_s[W][VALUE_W-1:0];
    end else begin : g_max_ext
      assign max_xor = {{(VALUE_W - W){1'b0}}, acc_s[W]};
    end
  endgenerate

  assign m_axis_tvalid = ctl_s[W].vld;
  assign m_axis_tdata  = {{(OUT_DATA_W - 1 - RANK_W - VALUE_W){1'b0}}, max_xor, rank, in_span};

endmodule

>>> hw/rtl/xlb_cell.sv
module xlb_cell #(
  parameter int W  = 31,
  parameter int RW = 5,
  parameter int I  = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  xlb_pkg::ctl_t ctl_i,
  input  logic [W-1:0]  vec_i,
  input  logic [W-1:0]  acc_i,
  input  logic [RW-1:0] rank_i,
  output xlb_pkg::ctl_t ctl_o,
  output logic [W-1:0]  vec_o,
  output logic [W-1:0]  acc_o,
  output logic [RW-1:0] rank_o
);
  import xlb_pkg::*;

  // row_q is zero or has its leading one at bit I
  logic [W-1:0]  row_q, row_d;
  ctl_t          ctl_q, ctl_d;
  logic [W-1:0]  vec_q, vec_d;
  logic [W-1:0]  acc_q, acc_d;
  logic [RW-1:0] rank_q, rank_d;
  logic          hit;

  always_comb begin
    row_d = row_q;
    ctl_d = ctl_i;
    vec_d = vec_i;
    hit   = !ctl_i.done && vec_i[I];
    case (ctl_i.mode)
      MODE_INSERT, MODE_TEST: begin
        if (hit) begin
          if (row_q[I]) begin
            vec_d = vec_i ^ row_q;
          end else begin
            ctl_d.done = 1'b1;
            if (ctl_i.mode == MODE_INSERT) begin
              row_d = vec_i;
            end
          end
        end
      end
      MODE_CLEAR: begin
        row_d = '0;
      end
      default: begin
      end
    endcase
    // greedy max over the rows as they stand after this request
    acc_d  = acc_i[I] ? acc_i : (acc_i ^ row_d);
    rank_d = rank_i + RW'(row_d[I]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_d;
      if (ctl_i.vld) begin
        row_q <= row_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vec_q  <= vec_d;
      acc_q  <= acc_d;
      rank_q <= rank_d;
    end
  end

  assign ctl_o  = ctl_q;
  assign vec_o  = vec_q;
  assign acc_o  = acc_q;
  assign rank_o = rank_q;

endmodule

>>> tb/xor_linear_basis_tb.sv
`timescale 1ns / 1ps

module xor_linear_basis_tb;
  import xlb_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int                DRAIN_CYC   = 48;
  localparam int                RAND_REQS   = 550;

  // response layout, lowest bit first: in_span, rank, max_xor
  typedef struct packed {
    logic [VALUE_W-1:0] max_xor;
    logic [RANK_W-1:0]  rank;
    logic               in_span;
  } basis_resp_t;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [VALUE_W-1:0] value;
  } basis_req_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;  // value, zero pad
  logic [MODE_W-1:0]     s_axis_tuser = '0;  // mode
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b1;
  logic [OUT_DATA_W-1:0] m_axis_tdata;       // in_span, rank, max_xor, zero pad

  basis_req_t  pending_reqs[$];
  basis_resp_t expected_resps[$];
  logic [VALUE_W-1:0] span_pool[$];
  logic [VALUE_W-1:0] model_rows[VALUE_W];

  logic req_fire = 1'b0;
  int unsigned req_cnt = 0;
  int unsigned resp_cnt = 0;
  int unsigned err_cnt = 0;
  int unsigned full_rank_cnt = 0;
  int unsigned span_hit_cnt = 0;
  int unsigned clear_cnt = 0;

  xor_linear_basis i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // Greedy elimination against the basis rows; updates the rows and returns
  // the response the step must produce.
  function automatic basis_resp_t basis_step(logic [MODE_W-1:0] mode,
                                             logic [VALUE_W-1:0] value);
    logic [VALUE_W-1:0] rem;
    logic [VALUE_W-1:0] acc;
    basis_resp_t        resp;
    int                 lead;
    rem  = value;
    acc  = '0;
    resp = '0;
    lead = -1;
    if (mode == MODE_INSERT || mode == MODE_TEST) begin
      for (int i = VALUE_W - 1; i >= 0; i--) begin
        if (rem[i] && lead < 0) begin
          if (model_rows[i] != '0) rem ^= model_rows[i];
          else lead = i;
        end
      end
      resp.in_span = (rem == '0);
      if (mode == MODE_INSERT && lead >= 0) model_rows[lead] = rem;
    end else if (mode == MODE_CLEAR) begin
      for (int i = 0; i < VALUE_W; i++) model_rows[i] = '0;
    end
    for (int i = VALUE_W - 1; i >= 0; i--) begin
      if (model_rows[i] != '0) resp.rank++;
      if (!acc[i]) acc ^= model_rows[i];
    end
    resp.max_xor = acc;
    return resp;
  endfunction

  function automatic void check_field(string name, logic [VALUE_W-1:0] want,
                                      logic [VALUE_W-1:0] got);
    if (got !== want) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endfunction

  task automatic queue_req(logic [MODE_W-1:0] mode, logic [VALUE_W-1:0] value);
    basis_req_t req;
    req.mode  = mode;
    req.value = value;
    pending_reqs.insert(pending_reqs.size(), req);
    if (mode == MODE_INSERT) begin
      span_pool.insert(span_pool.size(), value);
      if (span_pool.size() > 64) void'(span_pool.pop_front());
    end else if (mode == MODE_CLEAR) begin
      span_pool.delete();
    end
  endtask

  function automatic logic [VALUE_W-1:0] pool_combo();
    logic [VALUE_W-1:0] acc;
    int                 picks;
    acc = '0;
    if (span_pool.size() == 0) return acc;
    picks = $urandom_range(1, 4);
    for (int k = 0; k < picks; k++)
      acc ^= span_pool[$urandom_range(span_pool.size() - 1)];
    return acc;
  endfunction

  function automatic logic [VALUE_W-1:0] rand_vector();
    logic [VALUE_W-1:0] v;
    int unsigned        kind;
    kind = $urandom_range(99);
    v    = '0;
    if (kind < 55) begin
      v = VALUE_W'($urandom());
    end else if (kind < 80) begin
      for (int k = $urandom_range(1, 3); k > 0; k--) v[$urandom_range(VALUE_W - 1)] = 1'b1;
    end else if (kind < 90) begin
      v = VALUE_W'($urandom()) >> $urandom_range(VALUE_W - 1);
    end else if (kind < 95) begin
      v = '1;
    end
    return v;
  endfunction

  // driver
  always @(negedge clk_i) begin
    int unsigned phase;
    logic        hold;
    basis_req_t  nxt;
    phase = (req_cnt / 64) % 4;
    if (rst_ni) begin
      if (!s_axis_tvalid || req_fire) begin
        hold = (phase == 1 && $urandom_range(99) < 56) ||
               (phase == 3 && $urandom_range(99) < 23);
        if (pending_reqs.size() != 0 && !hold) begin
          nxt = pending_reqs.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= IN_DATA_W'(nxt.value);
          s_axis_tuser  <= nxt.mode;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= !((phase == 2 && $urandom_range(99) < 56) ||
                         (phase == 3 && $urandom_range(99) < 23));
    end
  end

  // monitor and scoreboard
  always @(posedge clk_i) begin
    basis_resp_t got;
    basis_resp_t want;
    if (rst_ni) begin
      req_fire <= s_axis_tvalid && s_axis_tready;
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[RANK_W+VALUE_W:0];
        resp_cnt++;
        if (got.rank == RANK_W'(VALUE_W)) full_rank_cnt++;
        if (got.in_span) span_hit_cnt++;
        if (expected_resps.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected response, expected none, actual 0x%0h", $time, got);
        end else begin
          want = expected_resps.pop_front();
          check_field("in_span", VALUE_W'(want.in_span), VALUE_W'(got.in_span));
          check_field("rank", VALUE_W'(want.rank), VALUE_W'(got.rank));
          check_field("max_xor", want.max_xor, got.max_xor);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        req_cnt++;
        if (s_axis_tuser == MODE_CLEAR) clear_cnt++;
        expected_resps.insert(expected_resps.size(),
                              basis_step(s_axis_tuser, s_axis_tdata[VALUE_W-1:0]));
      end
    end else begin
      req_fire <= 1'b0;
    end
  end

  initial begin
    int unsigned roll;
    for (int i = 0; i < VALUE_W; i++) model_rows[i] = '0;

    queue_req(MODE_TEST,   31'h0000_0000);
    queue_req(MODE_TEST,   31'h7FFF_FFFF);
    queue_req(MODE_INSERT, 31'h0000_0000);
    queue_req(MODE_UNUSED, 31'h1234_5678);
    queue_req(MODE_INSERT, 31'h7FFF_FFFF);
    queue_req(MODE_INSERT, 31'h4000_0000);
    queue_req(MODE_INSERT, 31'h0000_0001);
    queue_req(MODE_INSERT, 31'h7FFF_FFFF);
    queue_req(MODE_TEST,   31'h3FFF_FFFE);
    queue_req(MODE_TEST,   31'h0000_0002);
    queue_req(MODE_INSERT, 31'h2AAA_AAAA);
    queue_req(MODE_INSERT, 31'h5555_5555);
    queue_req(MODE_UNUSED, 31'h7FFF_FFFF);
    queue_req(MODE_TEST,   31'h7FFF_FFFF);
    queue_req(MODE_CLEAR,  31'h0000_0000);
    queue_req(MODE_TEST,   31'h0000_0001);
    queue_req(MODE_INSERT, 31'h0000_0001);
    queue_req(MODE_INSERT, 31'h0000_0003);
    queue_req(MODE_TEST,   31'h0000_0002);
    queue_req(MODE_CLEAR,  31'h7FFF_FFFF);

    // mostly insert/test runs between rare clears; tests lean on known span members
    for (int n = 0; n < RAND_REQS; n++) begin
      roll = $urandom_range(199);
      if (roll < 3) begin
        queue_req(MODE_CLEAR, VALUE_W'($urandom()));
      end else if (roll < 7) begin
        queue_req(MODE_UNUSED, VALUE_W'($urandom()));
      end else if (roll < 110) begin
        queue_req(MODE_INSERT, ($urandom_range(99) < 15) ? pool_combo() : rand_vector());
      end else begin
        queue_req(MODE_TEST, ($urandom_range(99) < 50) ? pool_combo() : rand_vector());
      end
    end

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_reqs.size() != 0 || s_axis_tvalid || expected_resps.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);

    $display("Checked %0d requests and %0d responses (%0d clears).",
             req_cnt, resp_cnt, clear_cnt);
    $display("Responses in span: %0d, at full rank: %0d.", span_hit_cnt, full_rank_cnt);
    if (err_cnt == 0 && expected_resps.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d responses outstanding", expected_resps.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
